// ----- rtl/core/clle_pkg.sv -----
// Package for the character linked-list engine: sizes, action and status codes.
// No dependencies.
package clle_pkg;
   localparam int CAPACITY = 32;
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef logic [IDX_W-1:0] idx_type;

   typedef enum logic [2:0] {
      ACT_HEAD   = 3'd0,
      ACT_TAIL   = 3'd1,
      ACT_AFTER  = 3'd2,
      ACT_BEFORE = 3'd3,
      ACT_REMOVE = 3'd4,
      ACT_TRAV   = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_MISS  = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;
endpackage

// ----- rtl/core/char_linked_list_engine.sv -----
// Character linked-list engine top level: node pool memory, sequencer, output register.
// Depends on clle_pkg.
//
//  channel  dir  ports                              meaning
//  req      in   req_valid/stall, action, key, new  one list action per request
//  rsp      out  rsp_valid/stall, status, char,last one or more results per request
//
// One request at a time. A search or tail walk visits each node as an address
// step, then a registered read of the node memory; an insert or remove writes
// after the walk. A traverse visits each node as address, data and result, and
// gives one result per node, so up to CAPACITY results per request.
// Reset clears pointers and count and starts the free-list init pass: after
// reset the engine chains all nodes into the free list before taking requests.
// A stalled result holds the engine in its emit state; nothing is lost.
module char_linked_list_engine import clle_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_action,
   input  logic [7:0] req_key_char,
   input  logic [7:0] req_new_char,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last
);
   typedef enum logic [7:0] {
      S_INIT = 8'b0000_0001,
      S_IDLE = 8'b0000_0010,
      S_RADR = 8'b0000_0100,  // address presented, data next cycle
      S_RDAT = 8'b0000_1000,  // node data available
      S_LINK = 8'b0001_0000,  // allocated node's old link read back: next free node
      S_EMIT = 8'b0010_0000,  // single result waits
      S_TOUT = 8'b0100_0000,  // traverse result waits
      S_WAIT = 8'b1000_0000   // second write step for remove / before / after
   } state_type;

   // node memories, registered read
   logic [7:0] char_mem [CAPACITY];
   logic [IDX_W-1:0] link_mem [CAPACITY];
   logic [7:0] rd_char;
   idx_type    rd_link;
   idx_type    rd_addr;
   logic       char_we, link_we;
   idx_type    char_wa, link_wa;
   logic [7:0] char_wd;
   idx_type    link_wd;

   always_ff @(posedge clock) begin
      if (char_we) char_mem[char_wa] <= char_wd;
      if (link_we) link_mem[link_wa] <= link_wd;
      rd_char <= char_mem[rd_addr];
      rd_link <= link_mem[rd_addr];
   end

   state_type  state_ff, state_in;
   idx_type    head_ff, head_in, free_ff, free_in;
   logic       head_nil_ff, head_nil_in, free_nil_ff, free_nil_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [2:0] act_ff, act_in;
   logic [7:0] key_ff, key_in, nc_ff, nc_in;
   idx_type    cur_ff, cur_in, prev_ff, prev_in;
   logic       has_prev_ff, has_prev_in;
   logic [CNT_W-1:0] step_ff, step_in;
   logic [1:0] st_ff, st_in;
   logic [7:0] och_ff, och_in;
   logic       olast_ff, olast_in;
   logic       fin;

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = (state_ff == S_EMIT) || (state_ff == S_TOUT);
   assign rsp_status  = st_ff;
   assign rsp_out_char = och_ff;
   assign rsp_last    = olast_ff;

   always_comb begin
      state_in = state_ff; head_in = head_ff; head_nil_in = head_nil_ff;
      free_in = free_ff; free_nil_in = free_nil_ff; count_in = count_ff;
      act_in = act_ff; key_in = key_ff; nc_in = nc_ff;
      cur_in = cur_ff; prev_in = prev_ff; has_prev_in = has_prev_ff;
      step_in = step_ff; st_in = st_ff; och_in = och_ff; olast_in = olast_ff;
      rd_addr = cur_ff;
      char_we = 1'b0; char_wa = free_ff; char_wd = 8'd0;
      link_we = 1'b0; link_wa = free_ff; link_wd = '0;
      fin = 1'b0;
      case (state_ff)
         S_INIT: begin
            // chain node i to i+1; last link unused (free_nil marks end by count)
            link_we = 1'b1; link_wa = cur_ff; link_wd = cur_ff + idx_type'(1);
            cur_in = cur_ff + idx_type'(1);
            if (cur_ff == idx_type'(CAPACITY - 1)) begin
               state_in = S_IDLE;
               cur_in = '0;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               act_in = req_action; key_in = req_key_char; nc_in = req_new_char;
               st_in = ST_OK; och_in = 8'd0; olast_in = 1'b1;
               cur_in = head_ff; has_prev_in = 1'b0; step_in = '0;
               state_in = S_EMIT;
               case (req_action)
                  ACT_HEAD: begin
                     if (free_nil_ff) st_in = ST_FULL;
                     else begin
                        char_we = 1'b1; char_wd = req_key_char;
                        link_we = 1'b1; link_wd = head_ff;
                        head_in = free_ff; head_nil_in = 1'b0;
                        count_in = count_ff + 1'b1;
                        state_in = S_LINK;  // fetch next free
                        rd_addr = free_ff;
                        cur_in = free_ff;
                        act_in = ACT_HEAD;
                     end
                  end
                  ACT_TAIL: begin
                     if (free_nil_ff) st_in = ST_FULL;
                     else if (head_nil_ff) begin
                        char_we = 1'b1; char_wd = req_key_char;
                        head_in = free_ff; head_nil_in = 1'b0;
                        count_in = count_ff + 1'b1;
                        state_in = S_LINK; rd_addr = free_ff; cur_in = free_ff;
                     end else begin
                        rd_addr = head_ff; state_in = S_RDAT;
                     end
                  end
                  ACT_AFTER, ACT_BEFORE, ACT_REMOVE, ACT_TRAV: begin
                     if (head_nil_ff) st_in = ST_EMPTY;
                     else begin
                        rd_addr = head_ff; state_in = S_RDAT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_RADR: begin
            rd_addr = cur_ff; state_in = S_RDAT;
         end
         S_RDAT: begin
            fin = (step_ff == CNT_W'(count_ff - 1'b1));
            step_in = step_ff + 1'b1;
            case (act_ff)
               ACT_TRAV: begin
                  och_in = rd_char; olast_in = fin; st_in = ST_OK;
                  cur_in = rd_link; state_in = S_TOUT;
               end
               ACT_TAIL: begin
                  if (fin) begin
                     // cur is tail: link it to new node, write node
                     link_we = 1'b1; link_wa = cur_ff; link_wd = free_ff;
                     char_we = 1'b1; char_wd = key_ff;
                     count_in = count_ff + 1'b1;
                     rd_addr = free_ff; cur_in = free_ff; state_in = S_LINK;
                  end else begin
                     cur_in = rd_link; state_in = S_RADR;
                  end
               end
               default: begin
                  if (rd_char == key_ff) begin
                     if (act_ff == ACT_REMOVE) begin
                        if (has_prev_ff) begin
                           link_we = 1'b1; link_wa = prev_ff; link_wd = rd_link;
                        end else head_in = rd_link;
                        head_nil_in = !has_prev_ff && fin;
                        state_in = S_WAIT;  // relink hit into free list next
                        prev_in = rd_link;
                     end else if (free_nil_ff) begin
                        st_in = ST_FULL; state_in = S_EMIT;
                     end else if (act_ff == ACT_BEFORE) begin
                        char_we = 1'b1; char_wd = nc_ff;
                        link_we = 1'b1;
                        if (has_prev_ff) begin
                           // predecessor points at new node; new node's link next
                           link_wa = prev_ff; link_wd = free_ff;
                           state_in = S_WAIT;
                        end else begin
                           link_wd = cur_ff;
                           head_in = free_ff;
                           count_in = count_ff + 1'b1;
                           rd_addr = free_ff; cur_in = free_ff; state_in = S_LINK;
                        end
                     end else begin
                        // insert after: hit points at new node, keep hit's old link
                        char_we = 1'b1; char_wd = nc_ff;
                        link_we = 1'b1; link_wa = cur_ff; link_wd = free_ff;
                        prev_in = rd_link;
                        state_in = S_WAIT;
                     end
                  end else if (fin) begin
                     st_in = ST_MISS; state_in = S_EMIT;
                  end else begin
                     prev_in = cur_ff; has_prev_in = 1'b1;
                     cur_in = rd_link; state_in = S_RADR;
                  end
               end
            endcase
         end
         S_WAIT: begin
            // second write step for remove / before / after
            if (act_ff == ACT_REMOVE) begin
               link_we = 1'b1; link_wa = cur_ff; link_wd = free_ff;
               free_in = cur_ff; free_nil_in = 1'b0;
               count_in = count_ff - 1'b1;
               state_in = S_EMIT;
            end else begin
               // new node's link, read of its old link in the same cycle
               link_we = 1'b1;
               link_wa = free_ff;
               link_wd = (act_ff == ACT_BEFORE) ? cur_ff : prev_ff;
               count_in = count_ff + 1'b1;
               rd_addr = free_ff; cur_in = free_ff; state_in = S_LINK;
            end
         end
         S_LINK: begin
            // rd_link holds the allocated node's old link (read issued in the
            // cycle the node was allocated), i.e. the next free node
            free_in = rd_link;
            free_nil_in = (count_ff == CNT_W'(CAPACITY));
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         S_TOUT: begin
            if (!rsp_stall) state_in = olast_ff ? S_IDLE : S_RADR;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         head_ff <= '0; head_nil_ff <= 1'b1;
         free_ff <= '0; free_nil_ff <= 1'b0;
         count_ff <= '0;
         cur_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in; head_nil_ff <= head_nil_in;
         free_ff <= free_in; free_nil_ff <= free_nil_in;
         count_ff <= count_in;
         cur_ff <= cur_in;
      end
      act_ff <= act_in; key_ff <= key_in; nc_ff <= nc_in;
      prev_ff <= prev_in; has_prev_ff <= has_prev_in; step_ff <= step_in;
      st_ff <= st_in; och_ff <= och_in; olast_ff <= olast_in;
   end

   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY)) else $error("node count overflow");
   a_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (free_nil_ff == (count_ff == CNT_W'(CAPACITY))))
      else $error("free list end disagrees with count");
   a_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (head_nil_ff == (count_ff == '0)))
      else $error("head null disagrees with count");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_char))
      else $error("result dropped while stalled");
endmodule
